// ----- hw/rtl/qte_pkg.sv -----
// Shared types, widths and constants for the quaternion to Euler angle pipeline.
package qte_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_MAX        = 32;
    localparam int QUAT_FRAC_BITS    = 14;

    localparam int DW        = 45;
    localparam int AW        = 34;
    localparam int NORM_STEPS = 6;
    localparam int NORM_TOP   = 40;
    localparam int ISQ_W      = 61;
    localparam int ISQ_STEPS  = 31;

    localparam int YAW_LIMIT  = 12800;
    localparam int DECL_RESET = 883;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [AW-1:0] ang;
        logic                 zero;
    } rot_t;

    typedef struct packed {
        logic [ISQ_W-1:0] v;
        logic [ISQ_W-1:0] res;
    } isq_t;

    localparam logic [31:0] ATAN_BAM [CORDIC_MAX] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

endpackage

// ----- hw/rtl/quaternion_to_euler_angles.sv -----
// Top level: quaternion in, yaw/pitch/roll in 1/64 degree out.
// Fully pipelined: one quaternion beat per clock while the output is not
// stalled, one result beat per input beat, in order. Registers between the
// accepting edge and the edge that loads the output register: products, sums, square root
// input register and row of 31 cells for the pitch cosine, 6 normalizer cells,
// quadrant fold, CORDIC row, degree conversion, output.
// A stalled output freezes the whole pipeline; s_axis_tready follows from the
// output register state and m_axis_tready. declination_offset is written
// through cfg_we/cfg_wdata and should change only while no beat is in flight.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // q_w[15:0], q_x[31:16], q_y[47:32], q_z[63:48]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // yaw_angle[14:0], pitch_angle[28:15], roll_angle[43:29]
    output logic [0:0]  m_axis_tuser,   // asin_clamped[0]
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata       // declination_offset
);

    localparam int FB2      = 2 * qte_pkg::QUAT_FRAC_BITS;
    localparam int SHR      = (FB2 >= 30) ? FB2 - 30 : 0;
    localparam int SHL      = (FB2 >= 30) ? 0 : 30 - FB2;
    localparam int DLY      = qte_pkg::ISQ_STEPS + 2;
    localparam int ATAN_LAT = qte_pkg::NORM_STEPS + 1 + CORDIC_STAGES;
    localparam int LAT      = qte_pkg::ISQ_STEPS + 3 + ATAN_LAT + 1;

    localparam logic signed [33:0] ONE_Q = signed'(34'(64'(1) << FB2));
    localparam logic signed [16:0] YLIM  = 17'(qte_pkg::YAW_LIMIT);

    typedef struct packed {
        logic signed [33:0] yaw_y;
        logic signed [33:0] yaw_x;
        logic signed [33:0] roll_y;
        logic signed [33:0] roll_x;
        logic               s_neg;
        logic [30:0]        mag30;
        logic               clamped;
    } dly_t;

    function automatic logic signed [15:0] to_deg(input logic signed [qte_pkg::AW-1:0] b);
        logic [qte_pkg::AW-1:0]   mag;
        logic [qte_pkg::AW+5:0]   prod;
        logic [15:0]              r;
        mag  = (b < 0) ? qte_pkg::AW'(-b) : qte_pkg::AW'(b);
        prod = (qte_pkg::AW+6)'(mag) * (qte_pkg::AW+6)'(45) + (qte_pkg::AW+6)'(1 << 22);
        r    = 16'(prod >> 23);
        return (b < 0) ? signed'(-r) : signed'(r);
    endfunction

    logic               en;
    logic [LAT-1:0]     vld_reg;
    logic [LAT-1:0]     vld_next;
    logic signed [14:0] decl_reg;

    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xy_reg, wz_reg, wx_reg, yz_reg, xz_reg, wy_reg;

    dly_t               dly_reg [DLY];
    dly_t               dly_next;
    logic signed [33:0] s_raw;
    logic signed [33:0] s_cl;
    logic [33:0]        s_mag;

    logic [61:0]        sq;
    qte_pkg::isq_t      isq_s [qte_pkg::ISQ_STEPS+1];

    logic signed [qte_pkg::DW-1:0] p_y;
    logic signed [qte_pkg::DW-1:0] p_x;
    logic signed [qte_pkg::AW-1:0] yaw_bam, pitch_bam, roll_bam;

    logic [ATAN_LAT:0]  clamp_reg;
    logic signed [15:0] yaw_d_reg, pitch_d_reg, roll_d_reg;

    logic signed [16:0] yaw_s;
    logic signed [16:0] yaw_sat;
    logic signed [15:0] pitch_n;
    logic               out_valid_reg;
    logic [47:0]        out_data_reg;
    logic               out_user_reg;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    assign qw = signed'(s_axis_tdata[15:0]);
    assign qx = signed'(s_axis_tdata[31:16]);
    assign qy = signed'(s_axis_tdata[47:32]);
    assign qz = signed'(s_axis_tdata[63:48]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= 15'(qte_pkg::DECL_RESET);
        end
        else if (cfg_we)
        begin
            decl_reg <= signed'(cfg_wdata);
        end
    end

    assign vld_next = {vld_reg[LAT-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg <= qw * qw;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            xy_reg <= qx * qy;
            wz_reg <= qw * qz;
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xz_reg <= qx * qz;
            wy_reg <= qw * qy;
        end
    end

    always_comb
    begin
        dly_next.yaw_y  = (34'(xy_reg) + 34'(wz_reg)) <<< 1;
        dly_next.yaw_x  = 34'(ww_reg) + 34'(xx_reg) - 34'(yy_reg) - 34'(zz_reg);
        dly_next.roll_y = (34'(wx_reg) + 34'(yz_reg)) <<< 1;
        dly_next.roll_x = 34'(ww_reg) - 34'(xx_reg) - 34'(yy_reg) + 34'(zz_reg);
        s_raw = (34'(xz_reg) - 34'(wy_reg)) <<< 1;
        dly_next.clamped = (s_raw > ONE_Q) || (s_raw < -ONE_Q);
        if (s_raw > ONE_Q)
        begin
            s_cl = ONE_Q;
        end
        else if (s_raw < -ONE_Q)
        begin
            s_cl = -ONE_Q;
        end
        else
        begin
            s_cl = s_raw;
        end
        dly_next.s_neg = (s_cl < 0);
        s_mag = (s_cl < 0) ? 34'(-s_cl) : 34'(s_cl);
        dly_next.mag30 = 31'((s_mag >> SHR) << SHL);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= dly_next;
            for (int j = 1; j < DLY; j++)
            begin
                dly_reg[j] <= dly_reg[j-1];
            end
        end
    end

    assign sq = 62'(dly_reg[0].mag30) * 62'(dly_reg[0].mag30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            isq_s[0].v   <= qte_pkg::ISQ_W'((62'(1) << 60) - sq);
            isq_s[0].res <= '0;
        end
    end

    for (genvar k = 0; k < qte_pkg::ISQ_STEPS; k++)
    begin : g_isq
        qte_isqrt_cell #(
            .K(k)
        ) u_isq (
            .clk (clk),
            .en  (en),
            .din (isq_s[k]),
            .dout(isq_s[k+1])
        );
    end

    assign p_y = dly_reg[DLY-1].s_neg ? -qte_pkg::DW'(dly_reg[DLY-1].mag30)
                                      : qte_pkg::DW'(dly_reg[DLY-1].mag30);
    assign p_x = qte_pkg::DW'(isq_s[qte_pkg::ISQ_STEPS].res);

    qte_atan2 #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_yaw (
        .clk (clk),
        .en  (en),
        .y_in(qte_pkg::DW'(dly_reg[DLY-1].yaw_y)),
        .x_in(qte_pkg::DW'(dly_reg[DLY-1].yaw_x)),
        .ang (yaw_bam)
    );

    qte_atan2 #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_pitch (
        .clk (clk),
        .en  (en),
        .y_in(p_y),
        .x_in(p_x),
        .ang (pitch_bam)
    );

    qte_atan2 #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_roll (
        .clk (clk),
        .en  (en),
        .y_in(qte_pkg::DW'(dly_reg[DLY-1].roll_y)),
        .x_in(qte_pkg::DW'(dly_reg[DLY-1].roll_x)),
        .ang (roll_bam)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clamp_reg   <= {clamp_reg[ATAN_LAT-1:0], dly_reg[DLY-1].clamped};
            yaw_d_reg   <= to_deg(yaw_bam);
            pitch_d_reg <= to_deg(pitch_bam);
            roll_d_reg  <= to_deg(roll_bam);
        end
    end

    always_comb
    begin
        yaw_s = 17'(yaw_d_reg) - 17'(decl_reg);
        if (yaw_s > YLIM)
        begin
            yaw_sat = YLIM;
        end
        else if (yaw_s < -YLIM)
        begin
            yaw_sat = -YLIM;
        end
        else
        begin
            yaw_sat = yaw_s;
        end
        pitch_n = -pitch_d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {4'b0, roll_d_reg[14:0], pitch_n[13:0], yaw_sat[14:0]};
            out_user_reg <= clamp_reg[ATAN_LAT];
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_user_reg;

endmodule

// ----- hw/rtl/qte_norm_cell.sv -----
// One step of the vector normalizer: scales x and y by 2^SHIFT if both magnitudes stay below 2^(NORM_TOP+1).
module qte_norm_cell #(
    parameter int SHIFT = 1
) (
    input  logic          clk,
    input  logic          en,
    input  qte_pkg::rot_t din,
    output qte_pkg::rot_t dout
);

    logic [qte_pkg::DW-1:0] ax;
    logic [qte_pkg::DW-1:0] ay;
    logic [qte_pkg::DW-1:0] m;
    logic                   shift_ok;
    qte_pkg::rot_t          dout_reg;
    qte_pkg::rot_t          dout_next;

    always_comb
    begin
        ax = (din.x < 0) ? qte_pkg::DW'(-din.x) : qte_pkg::DW'(din.x);
        ay = (din.y < 0) ? qte_pkg::DW'(-din.y) : qte_pkg::DW'(din.y);
        m  = ax | ay;
        shift_ok = ((m >> (qte_pkg::NORM_TOP + 1 - SHIFT)) == '0);
        dout_next = din;
        if (shift_ok)
        begin
            dout_next.x = din.x <<< SHIFT;
            dout_next.y = din.y <<< SHIFT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ----- hw/rtl/qte_cordic_cell.sv -----
// One vectoring CORDIC micro-rotation, registered.
module qte_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic          clk,
    input  logic          en,
    input  qte_pkg::rot_t din,
    output qte_pkg::rot_t dout
);

    logic signed [qte_pkg::DW-1:0] dx;
    logic signed [qte_pkg::DW-1:0] dy;
    logic signed [qte_pkg::AW-1:0] step;
    qte_pkg::rot_t                 dout_reg;
    qte_pkg::rot_t                 dout_next;

    always_comb
    begin
        dx   = din.y >>> IDX;
        dy   = din.x >>> IDX;
        step = signed'(qte_pkg::AW'(qte_pkg::ATAN_BAM[IDX]));
        dout_next = din;
        if (din.y > 0)
        begin
            dout_next.x   = din.x + dx;
            dout_next.y   = din.y - dy;
            dout_next.ang = din.ang + step;
        end
        else
        begin
            dout_next.x   = din.x - dx;
            dout_next.y   = din.y + dy;
            dout_next.ang = din.ang - step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ----- hw/rtl/qte_isqrt_cell.sv -----
// One bit step of the integer square root, bit weight 2^(ISQ_W-1-2*K).
module qte_isqrt_cell #(
    parameter int K = 0
) (
    input  logic          clk,
    input  logic          en,
    input  qte_pkg::isq_t din,
    output qte_pkg::isq_t dout
);

    localparam logic [qte_pkg::ISQ_W-1:0] BIT_W =
        qte_pkg::ISQ_W'(1) << (qte_pkg::ISQ_W - 1 - 2 * K);

    logic [qte_pkg::ISQ_W:0] sum;
    qte_pkg::isq_t           dout_reg;
    qte_pkg::isq_t           dout_next;

    always_comb
    begin
        sum = {1'b0, din.res} + {1'b0, BIT_W};
        if ({1'b0, din.v} >= sum)
        begin
            dout_next.v   = din.v - sum[qte_pkg::ISQ_W-1:0];
            dout_next.res = (din.res >> 1) + BIT_W;
        end
        else
        begin
            dout_next.v   = din.v;
            dout_next.res = din.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ----- hw/rtl/qte_atan2.sv -----
// Pipelined atan2: normalizer cells, quadrant fold, then a row of CORDIC cells.
module qte_atan2 #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [qte_pkg::DW-1:0] y_in,
    input  logic signed [qte_pkg::DW-1:0] x_in,
    output logic signed [qte_pkg::AW-1:0] ang
);

    localparam logic signed [qte_pkg::AW-1:0] QUARTER = qte_pkg::AW'(32'h40000000);

    qte_pkg::rot_t norm_s [qte_pkg::NORM_STEPS+1];
    qte_pkg::rot_t rot_s  [CORDIC_STAGES+1];
    qte_pkg::rot_t fold_reg;
    qte_pkg::rot_t fold_next;
    qte_pkg::rot_t last;

    always_comb
    begin
        norm_s[0].x    = x_in;
        norm_s[0].y    = y_in;
        norm_s[0].ang  = '0;
        norm_s[0].zero = (x_in == 0) && (y_in == 0);
    end

    for (genvar j = 0; j < qte_pkg::NORM_STEPS; j++)
    begin : g_norm
        qte_norm_cell #(
            .SHIFT(1 << (qte_pkg::NORM_STEPS - 1 - j))
        ) u_norm (
            .clk (clk),
            .en  (en),
            .din (norm_s[j]),
            .dout(norm_s[j+1])
        );
    end

    always_comb
    begin
        last      = norm_s[qte_pkg::NORM_STEPS];
        fold_next = last;
        if (last.x < 0)
        begin
            if (last.y >= 0)
            begin
                fold_next.x   = last.y;
                fold_next.y   = -last.x;
                fold_next.ang = QUARTER;
            end
            else
            begin
                fold_next.x   = -last.y;
                fold_next.y   = last.x;
                fold_next.ang = -QUARTER;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_reg <= fold_next;
        end
    end

    assign rot_s[0] = fold_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_rot
        qte_cordic_cell #(
            .IDX(i)
        ) u_cell (
            .clk (clk),
            .en  (en),
            .din (rot_s[i]),
            .dout(rot_s[i+1])
        );
    end

    assign ang = rot_s[CORDIC_STAGES].zero ? '0 : rot_s[CORDIC_STAGES].ang;

endmodule
